// ----- hdl/gppt_pkg.sv -----
// ---------------------------------------------------------------------------
// gppt_pkg
// Shared types and constants for the greedy proximity point thinning unit.
// ---------------------------------------------------------------------------
package gppt_pkg;

    // field widths fixed by the register map and the result word
    localparam int THRESH_W     = 20;
    localparam int LIMIT_W      = 7;
    localparam int THR_SQ_W     = 2 * THRESH_W;
    localparam int CFG_IDX_W    = 2;

    // parameter defaults
    localparam int MAX_KEPT_DEF   = 64;
    localparam int COORD_BITS_DEF = 20;

    // register reset values
    localparam logic [THRESH_W-1:0] THRESH_RST = '0;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(1);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESH = 2'd0,
        CFG_LIMIT  = 2'd1
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // distance unit status toward the sequencer
    typedef struct packed {
        logic busy;
        logic hit_valid;
        logic hit;
    } t_dist_status;

endpackage

// ----- hdl/gppt_if.sv -----
// ---------------------------------------------------------------------------
// gppt interfaces
// Point, result and configuration channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface gppt_pt_if
    import gppt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic                         end_of_list;

    modport source (output valid, pos_x, pos_y, pos_z, end_of_list, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, end_of_list, output ready);
endinterface

interface gppt_res_if
    import gppt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         kept;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic [LIMIT_W-1:0]           kept_count;
    logic                         list_done;

    modport source (output valid, kept, out_x, out_y, out_z, kept_count, list_done,
                    input ready);
    modport sink   (input valid, kept, out_x, out_y, out_z, kept_count, list_done,
                    output ready);
endinterface

interface gppt_cfg_if
    import gppt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [THRESH_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/gppt_mem.sv -----
// ---------------------------------------------------------------------------
// gppt_mem
// Kept point store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module gppt_mem
    import gppt_pkg::*;
#(
    parameter int DEPTH  = MAX_KEPT_DEF,
    parameter int WIDTH  = 3 * COORD_BITS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/gppt_dist.sv -----
// ---------------------------------------------------------------------------
// gppt_dist
// Three stage squared distance check of the current point against one
// stored point per cycle: abs difference, square, sum and compare.
// ---------------------------------------------------------------------------
module gppt_dist
    import gppt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [3*COORD_BITS-1:0] i_point,
    input  logic [3*COORD_BITS-1:0] i_entry,
    input  logic [THR_SQ_W-1:0]     i_thr_sq,
    output t_dist_status            o_status
);

    localparam int D_W   = COORD_BITS + 1;
    localparam int SQ_W  = 2 * D_W;
    localparam int SUM_W = SQ_W + 2;
    localparam int CMP_W = (SUM_W > THR_SQ_W) ? SUM_W : THR_SQ_W;

    logic [D_W-1:0]   n_abs [3];
    logic [D_W-1:0]   r_abs [3];
    logic [SQ_W-1:0]  r_sq  [3];
    logic [SUM_W-1:0] sum;
    logic             r_v1;
    logic             r_v2;
    logic             r_v3;
    logic             r_hit;

    // per axis signed difference and magnitude
    always_comb begin
        logic signed [D_W-1:0] d;
        for (int a = 0; a < 3; a++) begin
            d = $signed({i_point[a*COORD_BITS+COORD_BITS-1],
                         i_point[a*COORD_BITS +: COORD_BITS]})
              - $signed({i_entry[a*COORD_BITS+COORD_BITS-1],
                         i_entry[a*COORD_BITS +: COORD_BITS]});
            n_abs[a] = d[D_W-1] ? D_W'(-d) : D_W'(d);
        end
    end

    assign sum = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_abs[a] <= n_abs[a];
            r_sq[a]  <= r_abs[a] * r_abs[a];
        end
        r_hit <= CMP_W'(sum) < CMP_W'(i_thr_sq);
    end

    assign o_status.busy      = r_v1 | r_v2 | r_v3;
    assign o_status.hit_valid = r_v3;
    assign o_status.hit       = r_hit;

endmodule

// ----- hdl/greedy_proximity_point_thinning_unit.sv -----
// ---------------------------------------------------------------------------
// greedy_proximity_point_thinning_unit
// Greedy distance suppression over a best-first stream of 3D points.
// ---------------------------------------------------------------------------
// Points enter on i_pt, one word each, best first; end_of_list marks the last
// point of a list. Every point gives one word on o_res: kept flag, echoed
// coordinates, number kept so far in the list and the list end marker.
// i_cfg writes the threshold (index 0) and the keep limit (index 1); it is
// always ready and should be written between points.
// A point is compared against every point kept so far in its list, one
// stored point a cycle read from the kept store and passed through a three
// stage distance pipeline. A point that needs no scan (empty list or limit
// reached) skips the comparison. The next point is accepted only once the
// result of the last one is in the output register; the kept store read
// port sets the rate.
// After reset the list is empty, the threshold is 0 and the limit is 1; the
// store needs no clearing pass. A result waits in the output register while
// the receiver stalls; the next point may be accepted and scanned meanwhile,
// but its result waits until the register frees.
// ---------------------------------------------------------------------------
module greedy_proximity_point_thinning_unit
    import gppt_pkg::*;
#(
    parameter int MAX_KEPT   = MAX_KEPT_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gppt_pt_if.sink    i_pt,
    gppt_res_if.source o_res,
    gppt_cfg_if.sink   i_cfg
);

    localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W  = $clog2(MAX_KEPT + 1);
    localparam int PT_W   = 3 * COORD_BITS;

    t_state               r_state;
    t_state               n_state;
    logic [THRESH_W-1:0]  r_thresh;
    logic [LIMIT_W-1:0]   r_max_spots;
    logic [LIMIT_W-1:0]   limit;
    logic [THR_SQ_W-1:0]  r_thr_sq;
    logic [CNT_W-1:0]     r_total;
    logic [CNT_W-1:0]     r_idx;
    logic [PT_W-1:0]      r_point;
    logic                 r_last;
    logic                 r_room;
    logic                 r_close;
    logic                 r_rd_v;
    logic [PT_W-1:0]      rdata;
    t_dist_status         dist_st;
    logic                 accept;
    logic                 scan_rd;
    logic                 out_free;
    logic                 finish;
    logic                 keep;
    logic [CNT_W-1:0]     next_total;
    logic                 r_out_valid;
    logic                 r_out_kept;
    logic [PT_W-1:0]      r_out_pt;
    logic [LIMIT_W-1:0]   r_out_count;
    logic                 r_out_done;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh    <= THRESH_RST;
            r_max_spots <= LIMIT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_THRESH: r_thresh    <= i_cfg.data;
                CFG_LIMIT:  r_max_spots <= i_cfg.data[LIMIT_W-1:0];
                default:    ;
            endcase
        end
    end

    // limit clamped to store capacity
    assign limit = (r_max_spots > LIMIT_W'(MAX_KEPT)) ? LIMIT_W'(MAX_KEPT) : r_max_spots;

    assign accept   = i_pt.valid && (r_state == ST_IDLE);
    assign i_pt.ready = (r_state == ST_IDLE);
    assign scan_rd  = (r_state == ST_SCAN);
    assign out_free = !r_out_valid || o_res.ready;
    assign finish   = (r_state == ST_FINISH) && out_free;
    assign keep     = r_room && !r_close;
    assign next_total = keep ? CNT_W'(r_total + 1'b1) : r_total;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_pt.valid) begin
                    if ((LIMIT_W'(r_total) < limit) && (r_total != '0)) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_SCAN: begin
                if (CNT_W'(r_idx + 1'b1) == r_total) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_v && !dist_st.busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // item control: list count, scan index, read valid, suppression flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_idx   <= '0;
            r_rd_v  <= 1'b0;
            r_close <= 1'b0;
            r_room  <= 1'b0;
        end else begin
            r_rd_v <= scan_rd;
            if (accept) begin
                r_idx   <= '0;
                r_close <= 1'b0;
                r_room  <= LIMIT_W'(r_total) < limit;
            end else begin
                if (scan_rd) begin
                    r_idx <= CNT_W'(r_idx + 1'b1);
                end
                if (dist_st.hit_valid && dist_st.hit) begin
                    r_close <= 1'b1;
                end
            end
            if (finish) begin
                r_total <= r_last ? '0 : next_total;
            end
        end
    end

    // point and squared threshold capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_point  <= {i_pt.pos_z, i_pt.pos_y, i_pt.pos_x};
            r_last   <= i_pt.end_of_list;
            r_thr_sq <= THR_SQ_W'(r_thresh) * THR_SQ_W'(r_thresh);
        end
    end

    // kept point store
    gppt_mem #(
        .DEPTH  (MAX_KEPT),
        .WIDTH  (PT_W),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (finish && keep),
        .i_waddr (r_total[ADDR_W-1:0]),
        .i_wdata (r_point),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    // distance check pipeline
    gppt_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_rd_v),
        .i_point  (r_point),
        .i_entry  (rdata),
        .i_thr_sq (r_thr_sq),
        .o_status (dist_st)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_kept  <= keep;
            r_out_pt    <= r_point;
            r_out_count <= LIMIT_W'(next_total);
            r_out_done  <= r_last;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.kept       = r_out_kept;
    assign o_res.out_x      = r_out_pt[0*COORD_BITS +: COORD_BITS];
    assign o_res.out_y      = r_out_pt[1*COORD_BITS +: COORD_BITS];
    assign o_res.out_z      = r_out_pt[2*COORD_BITS +: COORD_BITS];
    assign o_res.kept_count = r_out_count;
    assign o_res.list_done  = r_out_done;

endmodule
